// ===== hw/rtl/at_command_frame_parser_defines.svh =====
// Assertion macros for the AT command framer.
`ifndef AT_COMMAND_FRAME_PARSER_DEFINES_SVH
`define AT_COMMAND_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked at every clock edge, held off while reset is high.
`define ATCFP_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define ATCFP_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define ATCFP_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define ATCFP_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

// ===== hw/rtl/atcfp_pkg.sv =====
package atcfp_pkg;

  localparam int unsigned MAX_FRAME = 128;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned TMR_W     = 16;

  localparam logic [TMR_W-1:0] TIMEOUT_RESET = 16'd1000;

  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  localparam logic [CNT_W-1:0] HEAD_LEN = 8'd3;
  localparam logic [CNT_W-1:0] TAIL_LEN = 8'd2;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_VALID     = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_TIMEOUT   = 3'd4
  } status_t;

  // Expected header character at position 0..2.
  function automatic logic [7:0] head_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = CH_A;
      2'd1:    c = CH_T;
      default: c = CH_PLUS;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/at_command_frame_parser.sv =====
// AT command line framer. Each input transaction is either one received UART
// byte (mode 0) or one timer tick (mode 1), and every input transaction yields
// exactly one result transaction. Bytes gather into a frame that closes at the
// first CR LF; the result then reports valid (length above five, "AT+" header)
// or malformed, with total length, command name length and the offset and
// length of the parameter after the first '='. A byte arriving while the frame
// already holds MAX_FRAME bytes drops the frame as overflow; timeout_ticks
// ticks counted from a frame's first byte drop it as timeout. Throughput is one
// transaction per cycle while the result channel does not stall. A transaction
// passes from the input register through the single pass of frame logic into
// the result register. The timeout register may be written only while the
// block is idle. No memory, so no clearing pass after reset.
`include "at_command_frame_parser_defines.svh"

module at_command_frame_parser
  import atcfp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // configuration
  input  logic             cfg_wen,
  input  logic [TMR_W-1:0] cfg_wdata,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             mode,
  input  logic [7:0]       data,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic             frame_end,
  output status_t          status,
  output logic [7:0]       total_length,
  output logic [7:0]       name_length,
  output logic             has_param,
  output logic [7:0]       param_offset,
  output logic [7:0]       param_length
);

  localparam logic [CNT_W-1:0] MaxFrame = CNT_W'(MAX_FRAME);

  // Input register
  logic       in_full;
  logic       mode_q;
  logic [7:0] data_q;

  // Frame state
  logic [TMR_W-1:0] timeout_ticks;
  logic [CNT_W-1:0] byte_count;
  logic             header_good;
  logic             equal_seen;
  logic [CNT_W-1:0] equal_position;
  logic             last_was_cr;
  logic             timer_running;
  logic [TMR_W-1:0] timer_count;

  logic [CNT_W-1:0] byte_count_next;
  logic             header_good_next;
  logic             equal_seen_next;
  logic [CNT_W-1:0] equal_position_next;
  logic             last_was_cr_next;
  logic             timer_running_next;
  logic [TMR_W-1:0] timer_count_next;

  // Result of the transaction in the input register
  logic       r_end;
  status_t    r_status;
  logic [7:0] r_total;
  logic [7:0] r_name;
  logic       r_hp;
  logic [7:0] r_poff;
  logic [7:0] r_plen;

  logic process;
  logic in_take;

  // The held transaction moves on whenever the result register is free or
  // is being emptied this cycle.
  assign process  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !process;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (process) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_q <= mode;
      data_q <= data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wen) begin
      timeout_ticks <= cfg_wdata;
    end
  end

  // Single pass of frame logic
  always_comb begin
    logic [CNT_W-1:0] pos;
    logic [TMR_W-1:0] tick_count;
    logic             closed;
    logic [CNT_W-1:0] off;

    byte_count_next     = byte_count;
    header_good_next    = header_good;
    equal_seen_next     = equal_seen;
    equal_position_next = equal_position;
    last_was_cr_next    = last_was_cr;
    timer_running_next  = timer_running;
    timer_count_next    = timer_count;

    r_end    = 1'b0;
    r_status = ST_NONE;
    r_total  = '0;
    r_name   = '0;
    r_hp     = 1'b0;
    r_poff   = '0;
    r_plen   = '0;

    pos        = byte_count;
    tick_count = timer_count + 16'd1;
    closed     = 1'b0;
    off        = equal_position + 8'd1;

    if (mode_q == MODE_TICK) begin
      // A tick only matters while a frame is open. A zero limit trips at once.
      if (timer_running) begin
        timer_count_next = tick_count;
        if (tick_count >= timeout_ticks) begin
          closed   = 1'b1;
          r_end    = 1'b1;
          r_status = ST_TIMEOUT;
        end
      end
    end else if (byte_count >= MaxFrame) begin
      // Frame already full: discard the byte and drop the frame.
      closed   = 1'b1;
      r_end    = 1'b1;
      r_status = ST_OVERFLOW;
    end else begin
      if (byte_count == '0) begin
        timer_running_next = 1'b1;
        timer_count_next   = '0;
      end
      if (pos < HEAD_LEN && data_q != head_char(pos[1:0])) begin
        header_good_next = 1'b0;
      end
      if (data_q == CH_EQ && !equal_seen) begin
        equal_seen_next     = 1'b1;
        equal_position_next = pos;
      end
      byte_count_next  = pos + 8'd1;
      last_was_cr_next = (data_q == CH_CR);

      if (byte_count_next > TAIL_LEN && last_was_cr && data_q == CH_LF) begin
        closed  = 1'b1;
        r_end   = 1'b1;
        r_total = byte_count_next;
        if (byte_count_next > HEAD_LEN + TAIL_LEN && header_good_next) begin
          r_status = ST_VALID;
          if (equal_seen_next) begin
            r_name = equal_position_next;
            r_hp   = 1'b1;
            r_poff = off;
            r_plen = byte_count_next - off - TAIL_LEN;
          end else begin
            // No parameter: the name runs up to CR LF.
            r_name = byte_count_next - TAIL_LEN;
          end
        end else begin
          r_status = ST_MALFORMED;
        end
      end
    end

    // Every frame end clears the frame and stops the timer.
    if (closed) begin
      byte_count_next     = '0;
      header_good_next    = 1'b1;
      equal_seen_next     = 1'b0;
      equal_position_next = '0;
      last_was_cr_next    = 1'b0;
      timer_running_next  = 1'b0;
      timer_count_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      header_good    <= 1'b1;
      equal_seen     <= 1'b0;
      equal_position <= '0;
      last_was_cr    <= 1'b0;
      timer_running  <= 1'b0;
      timer_count    <= '0;
    end else if (process) begin
      byte_count     <= byte_count_next;
      header_good    <= header_good_next;
      equal_seen     <= equal_seen_next;
      equal_position <= equal_position_next;
      last_was_cr    <= last_was_cr_next;
      timer_running  <= timer_running_next;
      timer_count    <= timer_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      frame_end    <= r_end;
      status       <= r_status;
      total_length <= r_total;
      name_length  <= r_name;
      has_param    <= r_hp;
      param_offset <= r_poff;
      param_length <= r_plen;
    end
  end

  `ATCFP_ASSERT_ALWAYS(a_count_bound, clk, rst || byte_count <= MaxFrame, "byte count past frame size")
  `ATCFP_ASSERT(a_timer_open, clk, rst, timer_running == (byte_count != '0), "timer/frame mismatch")
  `ATCFP_ASSERT(a_end_status, clk, rst, out_valid |-> (frame_end == (status != ST_NONE)), "frame_end vs status")
  `ATCFP_ASSERT(a_valid_len, clk, rst, (out_valid && status == ST_VALID) |-> (total_length > HEAD_LEN + TAIL_LEN && name_length < total_length), "bad valid lengths")
  `ATCFP_ASSERT(a_hold_input, clk, rst, in_stall |=> (in_full && $stable(data_q) && $stable(mode_q)), "held input lost")

endmodule
